// ----- rtl/hard_nms_topk_macros.svh -----
// Assertion macros used by the back end of the block.
`ifndef HARD_NMS_TOPK_MACROS_SVH
`define HARD_NMS_TOPK_MACROS_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define HNT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define HNT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hnt_pkg.sv -----
package hnt_pkg;

	localparam int MAX_BOXES  = 1024;
	localparam int MAX_KEEP   = 64;
	localparam int IDX_W      = $clog2(MAX_BOXES);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int COORD_W    = 16;
	localparam int GEO_W      = 4 * COORD_W;
	localparam int SCORE_W    = 16;
	localparam int THR_W      = 16;
	localparam int KEEP_W     = 7;
	localparam int ENT_W      = GEO_W + SCORE_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic CFG_THR  = 1'b0;
	localparam logic CFG_KEEP = 1'b1;

	// One load command from the front: a box to store, and on the closing
	// box also the set summary (count and the best box seen).
	typedef struct packed {
		logic               wr;
		logic               last;
		logic [IDX_W-1:0]   idx;
		logic [GEO_W-1:0]   geo;
		logic [SCORE_W-1:0] score;
		logic [CNT_W-1:0]   cnt;
		logic [IDX_W-1:0]   best_idx;
		logic [SCORE_W-1:0] best_score;
		logic [GEO_W-1:0]   best_geo;
	} load_t;

	typedef struct packed {
		logic [THR_W-1:0]  thr;
		logic [KEEP_W-1:0] keep;
	} cfg_t;

endpackage

// ----- rtl/hnt_front.sv -----
module hnt_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [15:0]              box_x,
	input  logic [15:0]              box_y,
	input  logic [15:0]              box_width,
	input  logic [15:0]              box_height,
	input  logic [15:0]              box_score,
	input  logic                     set_end,
	input  logic                     fifo_full,
	output logic                     push,
	output hnt_pkg::load_t           entry
);
	import hnt_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [GEO_W-1:0]   best_geo_q;
	logic               store;
	logic               take;
	logic [GEO_W-1:0]   geo;

	assign in_ready = !fifo_full;
	assign push     = in_valid && in_ready;
	assign store    = (count_q != CNT_W'(MAX_BOXES));
	assign geo      = {box_height, box_width, box_y, box_x};
	// Strictly greater keeps the earliest box among equal scores.
	assign take     = store && ((count_q == '0) || (box_score > best_score_q));

	always_comb begin
		entry.wr         = store;
		entry.last       = set_end;
		entry.idx        = count_q[IDX_W-1:0];
		entry.geo        = geo;
		entry.score      = box_score;
		entry.cnt        = count_q + CNT_W'(store);
		entry.best_idx   = take ? count_q[IDX_W-1:0] : best_idx_q;
		entry.best_score = take ? box_score : best_score_q;
		entry.best_geo   = take ? geo : best_geo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= set_end ? '0 : entry.cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			best_idx_q   <= entry.best_idx;
			best_score_q <= entry.best_score;
			best_geo_q   <= entry.best_geo;
		end
	end

endmodule

// ----- rtl/hnt_fifo.sv -----
module hnt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hnt_pkg::load_t wdata,
	input  logic           pop,
	output hnt_pkg::load_t rdata,
	output logic           full,
	output logic           empty
);
	import hnt_pkg::*;

	load_t              slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

// ----- rtl/hnt_back.sv -----
module hnt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hnt_pkg::load_t q_data,
	input  logic           q_empty,
	output logic           q_pop,
	input  hnt_pkg::cfg_t  cfg,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    kept_x,
	output logic [15:0]    kept_y,
	output logic [15:0]    kept_width,
	output logic [15:0]    kept_height,
	output logic [15:0]    kept_score,
	output logic           final_kept
);
	import hnt_pkg::*;
	`include "hard_nms_topk_macros.svh"

	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_CHECK = 5'b00010,
		S_PASS  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	function automatic logic [16:0] overlap(input logic [15:0] a0, input logic [15:0] al,
		input logic [15:0] b0, input logic [15:0] bl);
		logic [16:0] a1;
		logic [16:0] b1;
		logic [16:0] lo;
		logic [16:0] hi;
		a1 = {1'b0, a0} + {1'b0, al};
		b1 = {1'b0, b0} + {1'b0, bl};
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? (hi - lo) : 17'd0;
	endfunction

	state_t             state_q;
	logic [ENT_W-1:0]   mem_q [MAX_BOXES];
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [ENT_W-1:0]   mem_wd;

	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   rd_ptr_q;
	logic [KEEP_W-1:0]  emitted_q;
	logic [KEEP_W-1:0]  lim_q;
	logic [KEEP_W-1:0]  lim;
	logic               fin_q;
	logic [IDX_W-1:0]   k_idx_q;
	logic [GEO_W-1:0]   k_geo_q;
	logic [SCORE_W-1:0] k_score_q;
	logic [31:0]        area_a_q;
	logic               best_v_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [GEO_W-1:0]   best_geo_q;
	logic [SCORE_W-1:0] best_score_q;

	logic               out_fin_q;
	logic [GEO_W-1:0]   out_geo_q;
	logic [SCORE_W-1:0] out_score_q;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IDX_W-1:0]   j_s1, j_s2, j_s3, j_s4, j_s5;
	logic [ENT_W-1:0]   rd_s1;
	logic [ENT_W-1:0]   e_s2, e_s3, e_s4, e_s5;
	logic [16:0]        ox_s2, oy_s2;
	logic [33:0]        inter_s3;
	logic [31:0]        areab_s3;
	logic [34:0]        uni_s4;
	logic [49:0]        ish_s4, ish_s5;
	logic [50:0]        prod_s5;

	logic               supp;
	logic               cand;
	logic               is_k;
	logic               emit_go;
	logic               last_rd;

	assign q_pop   = (state_q == S_LOAD) && !q_empty;
	assign emit_go = (state_q == S_EMIT) && (!out_valid || out_ready);
	assign last_rd = (rd_ptr_q == n_q - 1'b1);
	assign lim     = (cfg.keep == '0) ? KEEP_W'(1) :
		((cfg.keep > KEEP_W'(MAX_KEEP)) ? KEEP_W'(MAX_KEEP) : cfg.keep);

	// Ratio test done cross-multiplied: inter * 65536 > thr * union.
	assign supp = {1'b0, ish_s5} > prod_s5;
	assign cand = v_s5 && !e_s5[ENT_W-1];
	assign is_k = (j_s5 == k_idx_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = j_s5;
		mem_wd = {1'b1, e_s5[ENT_W-2:0]};
		if (q_pop && q_data.wr) begin
			mem_we = 1'b1;
			mem_wa = q_data.idx;
			mem_wd = {1'b0, q_data.score, q_data.geo};
		end else if (cand && (is_k || supp)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem_q[rd_ptr_q[IDX_W-1:0]];
	end

	// Overlap pipeline against the current kept box.
	always_ff @(posedge clk) begin
		j_s1     <= rd_ptr_q[IDX_W-1:0];
		j_s2     <= j_s1;
		e_s2     <= rd_s1;
		ox_s2    <= overlap(k_geo_q[15:0], k_geo_q[47:32], rd_s1[15:0], rd_s1[47:32]);
		oy_s2    <= overlap(k_geo_q[31:16], k_geo_q[63:48], rd_s1[31:16], rd_s1[63:48]);
		j_s3     <= j_s2;
		e_s3     <= e_s2;
		inter_s3 <= ox_s2 * oy_s2;
		areab_s3 <= e_s2[47:32] * e_s2[63:48];
		j_s4     <= j_s3;
		e_s4     <= e_s3;
		uni_s4   <= 35'(area_a_q) + 35'(areab_s3) - 35'(inter_s3);
		ish_s4   <= {inter_s3, 16'd0};
		j_s5     <= j_s4;
		e_s5     <= e_s4;
		ish_s5   <= ish_s4;
		prod_s5  <= 51'(cfg.thr) * 51'(uni_s4);
		area_a_q <= k_geo_q[47:32] * k_geo_q[63:48];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_PASS);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			out_valid <= 1'b0;
			n_q       <= '0;
			rd_ptr_q  <= '0;
			emitted_q <= '0;
			lim_q     <= KEEP_W'(1);
			fin_q     <= 1'b0;
			best_v_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cand && !is_k && !supp && (!best_v_q || e_s5[GEO_W+:SCORE_W] > best_score_q)) begin
				best_v_q <= 1'b1;
			end
			unique case (state_q)
				S_LOAD: begin
					if (q_pop && q_data.last) begin
						n_q       <= q_data.cnt;
						emitted_q <= '0;
						lim_q     <= lim;
						state_q   <= S_CHECK;
					end
				end
				S_CHECK: begin
					best_v_q <= 1'b0;
					rd_ptr_q <= '0;
					if (emitted_q + 1'b1 == lim_q) begin
						fin_q   <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					if (last_rd) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4 || v_s5)) begin
						fin_q   <= !best_v_q;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						emitted_q <= emitted_q + 1'b1;
						state_q   <= fin_q ? S_LOAD : S_CHECK;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cand && !is_k && !supp && (!best_v_q || e_s5[GEO_W+:SCORE_W] > best_score_q)) begin
			best_idx_q   <= j_s5;
			best_geo_q   <= e_s5[GEO_W-1:0];
			best_score_q <= e_s5[GEO_W+:SCORE_W];
		end
		if (q_pop && q_data.last) begin
			k_idx_q   <= q_data.best_idx;
			k_geo_q   <= q_data.best_geo;
			k_score_q <= q_data.best_score;
		end else if (emit_go && !fin_q) begin
			k_idx_q   <= best_idx_q;
			k_geo_q   <= best_geo_q;
			k_score_q <= best_score_q;
		end
		if (emit_go) begin
			out_geo_q   <= k_geo_q;
			out_score_q <= k_score_q;
			out_fin_q   <= fin_q;
		end
	end

	assign kept_x      = out_geo_q[15:0];
	assign kept_y      = out_geo_q[31:16];
	assign kept_width  = out_geo_q[47:32];
	assign kept_height = out_geo_q[63:48];
	assign kept_score  = out_score_q;
	assign final_kept  = out_fin_q;

	`HNT_ASSERT_IMPL(a_wb_in_set, v_s5, ({1'b0, j_s5} < n_q), "pass touched an entry past the set")
	`HNT_ASSERT_IMPL(a_lim, state_q == S_CHECK, emitted_q < lim_q, "kept count passed the limit")
	`HNT_ASSERT_IMPL(a_no_pop, state_q != S_LOAD, !q_pop, "queue popped during suppression")
	`HNT_ASSERT_NEXT(a_pass_end, (state_q == S_PASS) && last_rd, state_q == S_DRAIN,
		"pass did not stop after the last entry")

endmodule

// ----- rtl/hard_nms_topk.sv -----
// Greedy hard NMS with a top-k limit. Boxes are taken at one per cycle while
// the queue has room and pass through a four-entry queue into a single box
// memory of MAX_BOXES entries; the front tracks the best-scoring box while the
// set loads, so the first keep needs no search. After the set_end box reaches
// the memory, each kept box takes a step to check the limit, one pass over the
// n stored boxes (one read a cycle on the memory's read port), a drain of the
// overlap pipeline and a step to hand the box to the output register; that
// pass also finds the next box to keep. The last allowed keep needs no pass.
// Input stays open while suppression runs until the queue fills.
// There is no clearing pass after reset.
module hard_nms_topk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] box_x,
	input  logic [15:0] box_y,
	input  logic [15:0] box_width,
	input  logic [15:0] box_height,
	input  logic [15:0] box_score,
	input  logic        set_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] kept_x,
	output logic [15:0] kept_y,
	output logic [15:0] kept_width,
	output logic [15:0] kept_height,
	output logic [15:0] kept_score,
	output logic        final_kept
);
	import hnt_pkg::*;

	cfg_t  cfg_q;
	load_t push_data;
	load_t pop_data;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr  <= THR_W'(29491);
			cfg_q.keep <= KEEP_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THR:  cfg_q.thr  <= cfg_data[THR_W-1:0];
				CFG_KEEP: cfg_q.keep <= cfg_data[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	hnt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.box_x      (box_x),
		.box_y      (box_y),
		.box_width  (box_width),
		.box_height (box_height),
		.box_score  (box_score),
		.set_end    (set_end),
		.fifo_full  (full),
		.push       (push),
		.entry      (push_data)
	);

	hnt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (pop_data),
		.full   (full),
		.empty  (empty)
	);

	hnt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (pop_data),
		.q_empty     (empty),
		.q_pop       (pop),
		.cfg         (cfg_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kept_x      (kept_x),
		.kept_y      (kept_y),
		.kept_width  (kept_width),
		.kept_height (kept_height),
		.kept_score  (kept_score),
		.final_kept  (final_kept)
	);

endmodule

// ----- bench/hard_nms_topk_tb.sv -----
module hard_nms_topk_tb;
	import hnt_pkg::*;

	typedef struct {
		logic [15:0] x, y, w, h, s;
		logic        last;
	} box_t;

	typedef struct {
		logic [15:0] x, y, w, h, s;
		logic        fin;
	} kept_t;

	typedef struct {
		box_t  b;
		bit    typed;
		kept_t want;
	} row_t;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] box_x, box_y, box_width, box_height, box_score;
	logic        set_end;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] kept_x, kept_y, kept_width, kept_height, kept_score;
	logic        final_kept;

	hard_nms_topk u_dut (.*);

	// Predictor state: the loaded set in keep-priority order, and the registers.
	box_t        ranked[$];
	logic [15:0] thr_q;
	logic [6:0]  keep_q;
	kept_t       kept_due[$];
	int          errors;
	bit          quiet;
	bit          hold_long;
	int          sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic longint unsigned span(longint unsigned a0, longint unsigned al,
	                                         longint unsigned b0, longint unsigned bl);
		longint unsigned lo, hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	function automatic bit too_close(box_t a, box_t b);
		longint unsigned inter, uni;
		inter = span(a.x, a.w, b.x, b.w) * span(a.y, a.h, b.y, b.h);
		uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
		return (inter << 16) > longint'(thr_q) * uni;
	endfunction

	// Loads one box; on the closing box, runs greedy suppression into res.
	task automatic load_box(box_t b, ref kept_t res[$]);
		int   pos, limit;
		bit   gone[$];
		kept_t k;
		res.delete();
		if (ranked.size() < MAX_BOXES) begin
			pos = ranked.size();
			while (pos > 0 && ranked[pos-1].s < b.s)
				pos--;
			ranked.insert(pos, b);
		end
		if (b.last) begin
			limit = (keep_q == 0) ? 1 : ((keep_q > MAX_KEEP) ? MAX_KEEP : keep_q);
			foreach (ranked[i]) gone.insert(gone.size(), 1'b0);
			for (int i = 0; i < ranked.size() && res.size() < limit; i++) begin
				if (!gone[i]) begin
					gone[i] = 1'b1;
					k = '{ranked[i].x, ranked[i].y, ranked[i].w, ranked[i].h, ranked[i].s, 1'b0};
					res.insert(res.size(), k);
					for (int j = i + 1; j < ranked.size(); j++)
						if (!gone[j] && too_close(ranked[i], ranked[j]))
							gone[j] = 1'b1;
				end
			end
			if (res.size() > 0)
				res[res.size()-1].fin = 1'b1;
			ranked.delete();
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer_box(box_t b, bit typed, kept_t want);
		int    gap;
		kept_t res[$];
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		box_x <= b.x;
		box_y <= b.y;
		box_width <= b.w;
		box_height <= b.h;
		box_score <= b.s;
		set_end <= b.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		load_box(b, res);
		if (typed)
			kept_due.insert(kept_due.size(), want);
		else
			foreach (res[i]) kept_due.insert(kept_due.size(), res[i]);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_THR)
			thr_q = val;
		else
			keep_q = val[6:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (kept_due.size() > 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	function automatic box_t rand_box(bit wild, logic [15:0] bx, logic [15:0] by);
		box_t b;
		if (wild) begin
			b.x = 16'($urandom);
			b.y = 16'($urandom);
			b.w = 16'($urandom);
			b.h = 16'($urandom);
			b.s = 16'($urandom);
		end else begin
			b.x = bx + 16'($urandom_range(0, 96));
			b.y = by + 16'($urandom_range(0, 96));
			b.w = 16'($urandom_range(0, 160));
			b.h = 16'($urandom_range(0, 160));
			b.s = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		end
		b.last = 1'b0;
		return b;
	endfunction

	task automatic random_set(int n);
		box_t        b;
		kept_t       none;
		logic [15:0] bx, by;
		bit          wild;
		none = '{default: '0};
		bx = 16'($urandom_range(0, 65000));
		by = 16'($urandom_range(0, 65000));
		wild = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++) begin
			b = rand_box(wild, bx, by);
			b.last = (i == n - 1);
			offer_box(b, 1'b0, none);
		end
	endtask

	// Receiver: mostly ready, short and long stalls, one forced long hold-off.
	initial begin
		int stall, r;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (hold_long) begin
				out_ready <= 1'b0;
				stall = 400;
				hold_long = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (quiet || r < 65)
					out_ready <= 1'b1;
				else begin
					out_ready <= 1'b0;
					stall = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 50);
				end
			end
		end
	end

	always @(posedge clk) begin
		kept_t e;
		if (arst_n && out_valid && out_ready) begin
			if (kept_due.size() == 0) begin
				$error("kept box with nothing expected: x=%0h y=%0h", kept_x, kept_y);
				errors++;
			end else begin
				e = kept_due.pop_front();
				if (kept_x !== e.x) begin
					$error("kept_x expected %0h actual %0h", e.x, kept_x); errors++;
				end
				if (kept_y !== e.y) begin
					$error("kept_y expected %0h actual %0h", e.y, kept_y); errors++;
				end
				if (kept_width !== e.w) begin
					$error("kept_width expected %0h actual %0h", e.w, kept_width); errors++;
				end
				if (kept_height !== e.h) begin
					$error("kept_height expected %0h actual %0h", e.h, kept_height); errors++;
				end
				if (kept_score !== e.s) begin
					$error("kept_score expected %0h actual %0h", e.s, kept_score); errors++;
				end
				if (final_kept !== e.fin) begin
					$error("final_kept expected %0b actual %0b", e.fin, final_kept); errors++;
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		row_t        dir[$];
		kept_t       none;
		logic [15:0] thr_pick[4];
		logic [6:0]  keep_pick[6];
		int          phase;
		none = '{default: '0};
		errors = 0;
		sent = 0;
		quiet = 1'b0;
		hold_long = 1'b0;
		thr_q = 16'd29491;
		keep_q = 7'd64;
		cfg_we = 1'b0;
		cfg_index = CFG_THR;
		cfg_data = '0;
		in_valid = 1'b0;
		box_x = '0;
		box_y = '0;
		box_width = '0;
		box_height = '0;
		box_score = '0;
		set_end = 1'b0;

		// Single-box sets come back unchanged and marked final.
		dir.insert(dir.size(), row_t'{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
			1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}});
		dir.insert(dir.size(), row_t'{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1}, 1'b1,
			'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1}});
		// Boxes sharing only an edge.
		dir.insert(dir.size(), row_t'{'{16'd0, 16'd0, 16'd16, 16'd16, 16'd100, 1'b0}, 1'b0, none});
		dir.insert(dir.size(), row_t'{'{16'd16, 16'd0, 16'd16, 16'd16, 16'd200, 1'b1}, 1'b0, none});
		// Identical boxes with equal scores: the earlier transfer wins.
		dir.insert(dir.size(), row_t'{'{16'd10, 16'd10, 16'd32, 16'd32, 16'd500, 1'b0}, 1'b0, none});
		dir.insert(dir.size(), row_t'{'{16'd10, 16'd10, 16'd32, 16'd32, 16'd500, 1'b1}, 1'b0, none});
		// Two zero-area boxes have zero union and are both kept.
		dir.insert(dir.size(), row_t'{'{16'd5, 16'd5, 16'd0, 16'd0, 16'd300, 1'b0}, 1'b0, none});
		dir.insert(dir.size(), row_t'{'{16'd5, 16'd5, 16'd0, 16'd0, 16'd300, 1'b1}, 1'b0, none});
		// Overlap chain with scores out of order, far corner of the plane.
		dir.insert(dir.size(), row_t'{'{16'hFF00, 16'hFF00, 16'hFF, 16'hFF, 16'd7, 1'b0}, 1'b0, none});
		dir.insert(dir.size(), row_t'{'{16'hFF10, 16'hFF10, 16'hFF, 16'hFF, 16'hFFFF, 1'b0}, 1'b0,
			none});
		dir.insert(dir.size(), row_t'{'{16'hFF80, 16'hFF00, 16'h7F, 16'hFF, 16'd9, 1'b0}, 1'b0, none});
		dir.insert(dir.size(), row_t'{'{16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'd8, 1'b1}, 1'b0, none});

		@(posedge arst_n);
		@(negedge clk);
		foreach (dir[i])
			offer_box(dir[i].b, dir[i].typed, dir[i].want);
		drain_results();

		thr_pick = '{16'd0, 16'hFFFF, 16'd29491, 16'd16384};
		keep_pick = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd3};
		phase = 0;
		while (sent < 230) begin
			write_reg(CFG_THR, (phase % 5 == 4) ? 16'($urandom) : thr_pick[phase % 4]);
			write_reg(CFG_KEEP, (phase % 7 == 6) ? 16'($urandom_range(0, 127))
			                                     : {9'd0, keep_pick[phase % 6]});
			quiet = (phase % 4 == 3);
			if (phase == 2) begin
				// Results are held back while sets keep coming, so the input backs up.
				quiet = 1'b1;
				hold_long = 1'b1;
				repeat (6) random_set($urandom_range(3, 6));
			end else begin
				repeat ($urandom_range(2, 5)) random_set($urandom_range(1, 8));
			end
			drain_results();
			phase++;
		end
		repeat (50) @(negedge clk);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hnt_pkg.sv
rtl/hnt_front.sv
rtl/hnt_fifo.sv
rtl/hnt_back.sv
rtl/hard_nms_topk.sv
bench/hard_nms_topk_tb.sv
